FILE: sv/token_classifier_symbol_table_macros.svh
// ----------------------------------------------------------------------------
// Token classifier symbol table - assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOKEN_CLASSIFIER_SYMBOL_TABLE_MACROS_SVH
`define TOKEN_CLASSIFIER_SYMBOL_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define TCST_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcst assertion failed");
`define TCST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcst assertion failed");
`else
`define TCST_ASSERT(label, clk, rst_n, prop)
`define TCST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/tcst_pkg.sv
// ----------------------------------------------------------------------------
// Token classifier symbol table - package
// Beat types, class and error codes, fixed keyword table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcst_pkg;

  typedef logic [7:0][7:0] lexeme_t;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [2:0] CLS_KEYWORD   = 3'd0;
  localparam logic [2:0] CLS_OPERATOR  = 3'd1;
  localparam logic [2:0] CLS_SEPARATOR = 3'd2;
  localparam logic [2:0] CLS_STRING    = 3'd3;
  localparam logic [2:0] CLS_IDENT     = 3'd4;
  localparam logic [2:0] CLS_LITERAL   = 3'd5;

  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_TABLE_FULL = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED  = 2'd2;

  localparam int KW_COUNT = 11;

  localparam logic [63:0] KW_BYTES [KW_COUNT] = '{
    64'h746E69, 64'h64696F76, 64'h74616F6C66, 64'h6E7275746572,
    64'h28, 64'h29, 64'h7B, 64'h3D, 64'h7D, 64'h3B, 64'h2C
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd4, 4'd5, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
  };
  localparam logic [2:0] KW_CLS [KW_COUNT] = '{
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_OPERATOR, CLS_OPERATOR, CLS_SEPARATOR, CLS_OPERATOR,
    CLS_SEPARATOR, CLS_SEPARATOR, CLS_OPERATOR
  };

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_LITERAL,
    KIND_IDENT
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] cls;
    logic [3:0] kw_num;
  } class_info_t;

  typedef struct packed {
    logic [7:0] char_in;
  } in_t;

  typedef struct packed {
    logic [15:0] entry_index;
    logic [15:0] line_number;
    logic [2:0]  token_class;
    logic [15:0] class_number;
    logic [63:0] lexeme;
    logic [3:0]  lexeme_length;
    logic [1:0]  error_code;
  } out_t;

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

FILE: sv/tcst_stream_if.sv
// ----------------------------------------------------------------------------
// Token classifier symbol table - stream interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcst_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/token_classifier_symbol_table.sv
// ----------------------------------------------------------------------------
// Token classifier symbol table - top level
// Byte-stream lexer with an identifier table held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Each source byte is one input beat. Ordinary bytes and delimiters that end
// no token are accepted straight in the collect state. A delimiter that ends
// a token moves to the emit state for strings, keywords, operators and
// literals; an identifier checked against a non-empty table first passes
// through the search state, scanning the identifier RAM's single read port
// one entry a cycle. The result sits in an output register; the block holds
// off input while a new result waits for that register to free up.
`timescale 1ns / 1ps
`include "token_classifier_symbol_table_macros.svh"

module token_classifier_symbol_table #(
  parameter int MAX_TOKEN_BYTES = 8,
  parameter int IDENT_DEPTH     = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tcst_stream_if.sink    in_i,
  tcst_stream_if.source  out_o
);

  localparam int IdxW  = (IDENT_DEPTH > 1) ? $clog2(IDENT_DEPTH) : 1;
  localparam int UsedW = $clog2(IDENT_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_SEARCH  = 3'b010,
    ST_EMIT    = 3'b100
  } state_e;

  state_e            state_q, state_d;
  tcst_pkg::lexeme_t token_q, token_d;
  logic [3:0]        len_q, len_d;
  logic              trunc_q, trunc_d;
  logic [15:0]       line_q, line_d;
  logic [15:0]       entry_q, entry_d;
  logic [15:0]       lit_q, lit_d;
  logic [UsedW-1:0]  used_q, used_d;
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic              out_valid_q, out_valid_d;

  logic [2:0]        cls_q, cls_d;
  logic [15:0]       num_q, num_d;
  logic [1:0]        err_q, err_d;
  logic              nl_q, nl_d;
  tcst_pkg::out_t    out_q, out_d;

  logic [63:0]       mem [IDENT_DEPTH];
  logic [63:0]       rdata_q;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;

  tcst_pkg::class_info_t info;

  logic             in_beat;
  logic             out_free;
  logic             is_delim;
  logic [7:0]       ch;
  logic [UsedW-1:0] cmp_next;

  tcst_classify u_classify (
    .token_i (token_q),
    .len_i   (len_q),
    .info_o  (info)
  );

  assign in_i.ready  = (state_q == ST_COLLECT);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign in_beat  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign ch       = in_i.data.char_in;
  assign is_delim = (ch == tcst_pkg::CHAR_NL) || (ch == tcst_pkg::CHAR_SP);
  assign cmp_next = UsedW'(cmp_idx_q) + UsedW'(1);
  assign rd_addr  = (state_q == ST_SEARCH) ? cmp_idx_q + IdxW'(1) : '0;

  always_comb begin
    state_d     = state_q;
    token_d     = token_q;
    len_d       = len_q;
    trunc_d     = trunc_q;
    line_d      = line_q;
    entry_d     = entry_q;
    lit_d       = lit_q;
    used_d      = used_q;
    cmp_idx_d   = cmp_idx_q;
    out_valid_d = out_valid_q;
    cls_d       = cls_q;
    num_d       = num_q;
    err_d       = err_q;
    nl_d        = nl_q;
    out_d       = out_q;
    wr_en       = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_COLLECT: begin
        if (in_beat && !is_delim) begin
          if (len_q < 4'(MAX_TOKEN_BYTES)) begin
            token_d[len_q[2:0]] = ch;
            len_d               = len_q + 4'd1;
          end else begin
            trunc_d = 1'b1;
          end
        end else if (in_beat && len_q == 4'd0) begin
          token_d = '0;
          trunc_d = 1'b0;
          if (ch == tcst_pkg::CHAR_NL) begin
            line_d = tcst_pkg::sat_inc16(line_q);
          end
        end else if (in_beat) begin
          nl_d  = (ch == tcst_pkg::CHAR_NL);
          err_d = trunc_q ? tcst_pkg::ERR_TRUNCATED : tcst_pkg::ERR_OK;
          cls_d = info.cls;
          case (info.kind)
            tcst_pkg::KIND_FIXED: begin
              num_d   = 16'(info.kw_num);
              state_d = ST_EMIT;
            end
            tcst_pkg::KIND_LITERAL: begin
              lit_d   = tcst_pkg::sat_inc16(lit_q);
              num_d   = tcst_pkg::sat_inc16(lit_q);
              state_d = ST_EMIT;
            end
            tcst_pkg::KIND_IDENT: begin
              if (used_q == '0) begin
                wr_en   = 1'b1;
                used_d  = used_q + UsedW'(1);
                num_d   = 16'd1;
                state_d = ST_EMIT;
              end else begin
                cmp_idx_d = '0;
                state_d   = ST_SEARCH;
              end
            end
            default: begin
              state_d = ST_COLLECT;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (rdata_q == token_q) begin
          num_d   = 16'(cmp_next);
          state_d = ST_EMIT;
        end else if (cmp_next == used_q) begin
          if (used_q == UsedW'(IDENT_DEPTH)) begin
            num_d = 16'd0;
            err_d = tcst_pkg::ERR_TABLE_FULL;
          end else begin
            wr_en  = 1'b1;
            used_d = used_q + UsedW'(1);
            num_d  = 16'(used_q) + 16'd1;
          end
          state_d = ST_EMIT;
        end else begin
          cmp_idx_d = cmp_idx_q + IdxW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d.entry_index   = tcst_pkg::sat_inc16(entry_q);
          out_d.line_number   = line_q;
          out_d.token_class   = cls_q;
          out_d.class_number  = num_q;
          out_d.lexeme        = token_q;
          out_d.lexeme_length = len_q;
          out_d.error_code    = err_q;
          out_valid_d         = 1'b1;
          entry_d             = tcst_pkg::sat_inc16(entry_q);
          token_d             = '0;
          len_d               = 4'd0;
          trunc_d             = 1'b0;
          if (nl_q) begin
            line_d = tcst_pkg::sat_inc16(line_q);
          end
          state_d = ST_COLLECT;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      token_q     <= '0;
      len_q       <= 4'd0;
      trunc_q     <= 1'b0;
      line_q      <= 16'd1;
      entry_q     <= 16'd0;
      lit_q       <= 16'd0;
      used_q      <= '0;
      cmp_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      token_q     <= token_d;
      len_q       <= len_d;
      trunc_q     <= trunc_d;
      line_q      <= line_d;
      entry_q     <= entry_d;
      lit_q       <= lit_d;
      used_q      <= used_d;
      cmp_idx_q   <= cmp_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    num_q <= num_d;
    err_q <= err_d;
    nl_q  <= nl_d;
    out_q <= out_d;
  end

  // identifier RAM: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[used_q[IdxW-1:0]] <= token_q;
    end
    rdata_q <= mem[rd_addr];
  end

  `TCST_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= UsedW'(IDENT_DEPTH))
  `TCST_ASSERT(a_search_idx, clk_i, rst_ni, (state_q == ST_SEARCH) |-> (UsedW'(cmp_idx_q) < used_q))
  `TCST_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, (state_q == ST_EMIT) && out_free, (len_q == 4'd0) && out_valid_q)

endmodule

FILE: sv/tcst_classify.sv
// ----------------------------------------------------------------------------
// Token classifier symbol table - token classifier
// Sorts a collected token into string, keyword/operator/separator, literal or identifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcst_classify (
  input  tcst_pkg::lexeme_t     token_i,
  input  logic [3:0]            len_i,
  output tcst_pkg::class_info_t info_o
);

  always_comb begin
    logic       kw_hit;
    logic       digits;
    logic [2:0] kw_cls;
    logic [3:0] kw_num;
    kw_hit = 1'b0;
    kw_cls = tcst_pkg::CLS_KEYWORD;
    kw_num = 4'd0;
    for (int k = tcst_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (tcst_pkg::KW_LEN[k] == len_i && tcst_pkg::KW_BYTES[k] == token_i) begin
        kw_hit = 1'b1;
        kw_cls = tcst_pkg::KW_CLS[k];
        kw_num = 4'(k + 1);
      end
    end
    digits = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < len_i &&
          (token_i[k] < tcst_pkg::CHAR_ZERO || token_i[k] > tcst_pkg::CHAR_NINE)) begin
        digits = 1'b0;
      end
    end

    info_o.kind   = tcst_pkg::KIND_IDENT;
    info_o.cls    = tcst_pkg::CLS_IDENT;
    info_o.kw_num = 4'd0;
    if (token_i[0] == tcst_pkg::CHAR_QUOTE) begin
      info_o.kind = tcst_pkg::KIND_FIXED;
      info_o.cls  = tcst_pkg::CLS_STRING;
    end else if (kw_hit) begin
      info_o.kind   = tcst_pkg::KIND_FIXED;
      info_o.cls    = kw_cls;
      info_o.kw_num = kw_num;
    end else if (digits) begin
      info_o.kind = tcst_pkg::KIND_LITERAL;
      info_o.cls  = tcst_pkg::CLS_LITERAL;
    end
  end

endmodule

FILE: sim/tcst_entry_checker.sv
// ----------------------------------------------------------------------------
// Token classifier symbol table - entry checker
// Watches the byte and entry channels, keeps its own lexer state and
// identifier table, predicts each table entry and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcst_entry_checker
  import tcst_pkg::*;
#(
  parameter int MAX_TOKEN_BYTES = 8,
  parameter int IDENT_DEPTH     = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tcst_stream_if src_i,
  tcst_stream_if res_i,
  output int     fail_count_o,
  output int     pending_o,
  output int     checked_o
);

  logic [63:0] tok_bytes;
  int unsigned tok_len;
  bit          tok_cut;
  logic [15:0] line_no;
  logic [15:0] entry_cnt;
  logic [15:0] lit_cnt;
  logic [63:0] ident_tab [IDENT_DEPTH];
  int unsigned ident_cnt;
  out_t        expected_entries [$];
  int          fails = 0;
  int          checked = 0;

  assign fail_count_o = fails;
  assign pending_o    = expected_entries.size();
  assign checked_o    = checked;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%t mismatch on entry beat %0d: %s got %h want %h",
             $realtime, checked, what, got, want);
    fails++;
  endtask

  task automatic classify_byte(input logic [7:0] b);
    out_t        e;
    logic [2:0]  cls;
    logic [15:0] num;
    logic [1:0]  err;
    bit          hit;
    bit          digits;
    if (b != CHAR_NL && b != CHAR_SP) begin
      if (tok_len < MAX_TOKEN_BYTES) begin
        tok_bytes[8*tok_len +: 8] = b;
        tok_len++;
      end else begin
        tok_cut = 1'b1;
      end
      return;
    end
    if (tok_len != 0) begin
      hit = 1'b0;
      num = '0;
      err = ERR_OK;
      cls = CLS_IDENT;
      if (tok_bytes[7:0] == CHAR_QUOTE) begin
        cls = CLS_STRING;
        hit = 1'b1;
      end else begin
        for (int k = 0; k < KW_COUNT && !hit; k++) begin
          if (KW_LEN[k] == tok_len && KW_BYTES[k] == tok_bytes) begin
            cls = KW_CLS[k];
            num = 16'(k + 1);
            hit = 1'b1;
          end
        end
      end
      if (!hit) begin
        digits = 1'b1;
        for (int p = 0; p < tok_len; p++) begin
          if (tok_bytes[8*p +: 8] < CHAR_ZERO || tok_bytes[8*p +: 8] > CHAR_NINE) begin
            digits = 1'b0;
          end
        end
        if (digits) begin
          if (lit_cnt != 16'hFFFF) lit_cnt++;
          cls = CLS_LITERAL;
          num = lit_cnt;
        end else begin
          cls = CLS_IDENT;
          for (int k = 0; k < ident_cnt && !hit; k++) begin
            if (ident_tab[k] == tok_bytes) begin
              num = 16'(k + 1);
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (ident_cnt < IDENT_DEPTH) begin
              ident_tab[ident_cnt] = tok_bytes;
              ident_cnt++;
              num = 16'(ident_cnt);
            end else begin
              err = ERR_TABLE_FULL;
            end
          end
        end
      end
      if (err == ERR_OK && tok_cut) err = ERR_TRUNCATED;
      if (entry_cnt != 16'hFFFF) entry_cnt++;
      e.entry_index   = entry_cnt;
      e.line_number   = line_no;
      e.token_class   = cls;
      e.class_number  = num;
      e.lexeme        = tok_bytes;
      e.lexeme_length = 4'(tok_len);
      e.error_code    = err;
      expected_entries.push_back(e);
    end
    tok_bytes = '0;
    tok_len   = 0;
    tok_cut   = 1'b0;
    if (b == CHAR_NL && line_no != 16'hFFFF) line_no++;
  endtask

  task automatic check_entry(input out_t got);
    out_t want;
    if (expected_entries.size() == 0) begin
      report("entry with nothing pending, lexeme", got.lexeme, '0);
    end else begin
      want = expected_entries.pop_front();
      if (got.entry_index !== want.entry_index)
        report("entry_index", got.entry_index, want.entry_index);
      if (got.line_number !== want.line_number)
        report("line_number", got.line_number, want.line_number);
      if (got.token_class !== want.token_class)
        report("token_class", got.token_class, want.token_class);
      if (got.class_number !== want.class_number)
        report("class_number", got.class_number, want.class_number);
      if (got.lexeme !== want.lexeme)
        report("lexeme", got.lexeme, want.lexeme);
      if (got.lexeme_length !== want.lexeme_length)
        report("lexeme_length", got.lexeme_length, want.lexeme_length);
      if (got.error_code !== want.error_code)
        report("error_code", got.error_code, want.error_code);
    end
    checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_bytes = '0;
      tok_len   = 0;
      tok_cut   = 1'b0;
      line_no   = 16'd1;
      entry_cnt = '0;
      lit_cnt   = '0;
      ident_cnt = 0;
      expected_entries.delete();
    end else begin
      if (src_i.valid && src_i.ready) classify_byte(src_i.data.char_in);
      if (res_i.valid && res_i.ready) check_entry(res_i.data);
    end
  end

endmodule

FILE: sim/tb_token_classifier_symbol_table.sv
// ----------------------------------------------------------------------------
// Token classifier symbol table - testbench top
// Feeds source text byte by byte: a directed opening, random token streams,
// a quiet closing stretch and an unfinished last token, with random idling
// on both channels; the entry checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_token_classifier_symbol_table;
  import tcst_pkg::*;

  localparam int RANDOM_BYTES = 1050;
  localparam int QUIET_LIMIT  = 2000;
  localparam int POOL_SIZE    = 24;

  logic clk_i;
  logic rst_ni;

  tcst_stream_if #(.payload_t(in_t))  in_ch ();
  tcst_stream_if #(.payload_t(out_t)) out_ch ();

  int fail_count;
  int pending;
  int checked;
  int bytes_sent;
  int quiet = 0;
  bit idle_on;
  bit stall_en;

  logic [7:0]  text_q [$];
  logic [63:0] pool_w [POOL_SIZE];
  int          pool_n [POOL_SIZE];

  token_classifier_symbol_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tcst_entry_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_i        (in_ch),
    .res_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CHAR_NL || b == CHAR_SP) b = 8'h78;
    return b;
  endfunction

  function automatic int MAX_TOKEN_LEN();
    return 8;
  endfunction

  function automatic void build_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_n[i] = $urandom_range(1, MAX_TOKEN_LEN());
      pool_w[i] = '0;
      pool_w[i][7:0] = 8'($urandom_range(8'h61, 8'h7A));
      for (int j = 1; j < pool_n[i]; j++) begin
        pool_w[i][8*j +: 8] = ($urandom_range(0, 3) == 0) ? plain_byte()
                                                          : 8'($urandom_range(8'h61, 8'h7A));
      end
    end
  endfunction

  function automatic void gen_token();
    int kind;
    int k;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      k = $urandom_range(0, KW_COUNT - 1);
      for (int j = 0; j < KW_LEN[k]; j++) text_q.push_back(KW_BYTES[k][8*j +: 8]);
    end else if (kind < 45) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
      for (int j = 0; j < n; j++) text_q.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
    end else if (kind < 75) begin
      k = $urandom_range(0, POOL_SIZE - 1);
      for (int j = 0; j < pool_n[k]; j++) text_q.push_back(pool_w[k][8*j +: 8]);
    end else if (kind < 85) begin
      text_q.push_back(CHAR_QUOTE);
      n = $urandom_range(0, 11);
      for (int j = 0; j < n; j++) text_q.push_back(plain_byte());
    end else begin
      n = $urandom_range(1, 12);
      for (int j = 0; j < n; j++) text_q.push_back(8'($urandom_range(0, 255)));
    end
    text_q.push_back($urandom_range(0, 1) ? CHAR_SP : CHAR_NL);
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      for (int j = 0; j < n; j++) text_q.push_back($urandom_range(0, 1) ? CHAR_SP : CHAR_NL);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data.char_in <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input bit vary_idling);
    for (int i = 0; i < text_q.size(); i++) begin
      if (vary_idling && i % 100 == 0) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_en = ($urandom_range(0, 3) != 0);
      end
      send_byte(text_q[i]);
    end
    text_q.delete();
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_en && $urandom_range(0, 12) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d entries pending", QUIET_LIMIT, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data.char_in = '0;
    bytes_sent         = 0;
    idle_on            = 1'b1;
    stall_en           = 1'b1;
    build_pool();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keyword, lone quote, empty tokens, overlong literal, zero and 0xFF
    // bytes in an identifier and its repeat
    text_q = '{8'h69, 8'h6E, 8'h74, CHAR_SP, CHAR_QUOTE, CHAR_NL, CHAR_SP, CHAR_SP,
               8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
               CHAR_SP, 8'h00, 8'hFF, CHAR_NL, 8'h00, 8'hFF, CHAR_SP};
    send_text(1'b0);

    while (text_q.size() < RANDOM_BYTES) gen_token();
    send_text(1'b1);

    // no idling from here on
    idle_on  = 1'b0;
    stall_en = 1'b0;
    for (int i = 0; i < 20; i++) gen_token();
    send_text(1'b0);
    // last token has no delimiter and must never show up
    text_q = '{8'h61, 8'h62, 8'h63};
    send_text(1'b0);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d source bytes; %0d table entries checked across keywords, strings,",
             bytes_sent, checked);
    $display("literals, identifiers with a full table, truncation and an unfinished token.");
    if (pending != 0) $display("%0d expected entries never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
